/* rtl/rwa_pkg.sv */
// Package for the running window average block.
// Holds the state encodings and the queue status type; no dependencies.
package rwa_pkg;

  // Front control states, one-hot
  typedef enum logic [1:0] {
    FRONT_IDLE   = 2'b01,
    FRONT_UPDATE = 2'b10
  } front_state_t;

  // Divider control states, one-hot
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  // Status of the queue between front and divider
  typedef struct packed {
    logic full;
    logic empty;
  } rwa_qstat_t;

endpackage

/* rtl/running_window_average_core.sv */
// Top level of the running window average block.
// Instantiates rwa_front, rwa_queue and rwa_divider; depends on rwa_pkg.
//
// Usage:
//   Sample channel (sample_valid / sample_stall) carries one signed sample and
//   a sequence_start flag per transaction; a set flag empties the window first.
//   Mean channel (mean_valid / mean_stall) returns one mean per sample, in order.
//   Config channel (cfg_valid / cfg_ready) writes window_length; ready is high
//   while the front is idle, and every write also empties the window.
//   Write only while idle; samples are held off while cfg_valid is high.
// Flow:
//   The front takes one sample at a time (ring read, then sum update) and takes
//   no new one until the sum is pushed. The divider is bit-serial, one quotient
//   bit per cycle, and works on one sum/count pair at a time; the divider sets
//   the sustained rate.
// Reset: rst (synchronous) empties the window and sets a window of one. The
//   history ring is not cleared; only entries written since the last clear are read.
// Stall: a stalled mean holds in the output register; the divider then waits,
//   the queue fills, and sample_stall rises.
module running_window_average_core import rwa_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [8:0]                    window_length,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          sequence_start,
  output logic                          mean_valid,
  input  logic                          mean_stall,
  output logic signed [SAMPLE_BITS-1:0] window_mean
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int QW = SAMPLE_BITS + 2 * CW;

  rwa_qstat_t    qstat;
  logic          push;
  logic          pop;
  logic [QW-1:0] push_data;
  logic [QW-1:0] pop_data;

  // Accept and accumulate
  rwa_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .window_length  (window_length),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_value   (sample_value),
    .sequence_start (sequence_start),
    .qstat          (qstat),
    .push           (push),
    .push_data      (push_data)
  );

  // Decouple front and divider
  rwa_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  // Divide and deliver
  rwa_divider #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .pop_data    (pop_data),
    .pop         (pop),
    .mean_valid  (mean_valid),
    .mean_stall  (mean_stall),
    .window_mean (window_mean)
  );

endmodule

/* rtl/rwa_queue.sv */
// Two-entry queue that carries sum/count pairs from the front to the divider.
// Depends on rwa_pkg for the status struct.
module rwa_queue import rwa_pkg::*; #(
  parameter int WIDTH = 50
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output rwa_qstat_t       stat
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign pop_data   = entry[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !stat.full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !stat.empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !stat.full, pop && !stat.empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/rwa_front.sv */
// Front part: accepts samples, keeps the history ring, fill count and running sum,
// and pushes each new sum/count pair to the queue. Depends on rwa_pkg.
module rwa_front import rwa_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cfg_valid,
  output logic                                                cfg_ready,
  input  logic [8:0]                                          window_length,
  input  logic                                                sample_valid,
  output logic                                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]                       sample_value,
  input  logic                                                sequence_start,
  input  rwa_qstat_t                                          qstat,
  output logic                                                push,
  output logic [SAMPLE_BITS+2*$clog2(MAX_WINDOW+1)-1:0]       push_data
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = SAMPLE_BITS + CW;
  localparam logic [CW-1:0] MAXW   = CW'(MAX_WINDOW);
  localparam logic [CW:0]   MAXD   = (CW+1)'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST   = AW'(MAX_WINDOW - 1);

  front_state_t             state;
  logic [CW-1:0]            win;
  logic [AW-1:0]            slot;
  logic [CW-1:0]            fill_count;
  logic signed [SW-1:0]     running_sum;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic                     do_sub;
  logic [SAMPLE_BITS-1:0]   ring [MAX_WINDOW];

  logic                     accept;
  logic                     cfg_write;
  logic                     commit;
  logic [AW-1:0]            slot_eff;
  logic [CW-1:0]            fill_eff;
  logic [CW:0]              oldest_raw;
  logic [AW-1:0]            oldest;
  logic [CW-1:0]            win_next;
  logic signed [SW-1:0]     sample_ext;
  logic signed [SW-1:0]     oldest_ext;
  logic signed [SW-1:0]     sum_next;
  logic [CW-1:0]            fill_next;

  // Take register writes and samples only while idle; a write goes first
  assign cfg_ready    = (state == FRONT_IDLE);
  assign cfg_write    = cfg_valid && cfg_ready;
  assign sample_stall = (state != FRONT_IDLE) || cfg_valid;
  assign accept       = sample_valid && !sample_stall;
  assign commit       = (state == FRONT_UPDATE) && !qstat.full;

  // Clamp the register to a window of one up to MAX_WINDOW
  always_comb begin
    if (window_length <= 9'd1) begin
      win_next = CW'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      win_next = MAXW;
    end else begin
      win_next = CW'(window_length);
    end
  end

  // Ring position of the oldest held sample, after an optional clear
  always_comb begin
    slot_eff   = sequence_start ? '0 : slot;
    fill_eff   = sequence_start ? '0 : fill_count;
    oldest_raw = (CW+1)'(slot_eff) + MAXD - (CW+1)'(win);
    if (oldest_raw >= MAXD) begin
      oldest_raw = oldest_raw - MAXD;
    end
    oldest = oldest_raw[AW-1:0];
  end

  // New sum and count: drop the oldest sample when full, add the new one
  always_comb begin
    sample_ext = SW'(signed'(sample_q));
    oldest_ext = do_sub ? SW'(signed'(rd_data)) : '0;
    sum_next   = running_sum - oldest_ext + sample_ext;
    fill_next  = do_sub ? fill_count : fill_count + CW'(1);
  end

  assign push      = commit;
  assign push_data = {sum_next, fill_next};

  // History ring: read the oldest entry on accept, write the sample on commit
  always_ff @(posedge clk) begin
    if (commit) begin
      ring[slot] <= sample_q;
    end
    if (accept) begin
      rd_data <= ring[oldest];
    end
  end

  // Latch the transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_value;
      do_sub   <= (fill_eff >= win);
    end
  end

  // Control, window register and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FRONT_IDLE;
      win         <= CW'(1);
      slot        <= '0;
      fill_count  <= '0;
      running_sum <= '0;
    end else begin
      unique case (state)
        FRONT_IDLE: begin
          if (cfg_write) begin
            win         <= win_next;
            slot        <= '0;
            fill_count  <= '0;
            running_sum <= '0;
          end else if (accept) begin
            slot        <= slot_eff;
            fill_count  <= fill_eff;
            if (sequence_start) begin
              running_sum <= '0;
            end
            state <= FRONT_UPDATE;
          end
        end
        FRONT_UPDATE: begin
          if (commit) begin
            running_sum <= sum_next;
            fill_count  <= fill_next;
            slot        <= (slot == LAST) ? '0 : slot + AW'(1);
            state       <= FRONT_IDLE;
          end
        end
        default: state <= FRONT_IDLE;
      endcase
    end
  end

  // A start flag empties the window
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && sequence_start |=> fill_count == '0 && running_sum == '0)
    else $error("sequence start did not empty the window");

  // Fill count never exceeds the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= win)
    else $error("fill count above window length");

endmodule

/* rtl/rwa_divider.sv */
// Back part: bit-serial signed-by-unsigned divider that turns a sum/count pair
// into the mean, truncated toward zero, and holds it in the output register.
// Depends on rwa_pkg.
module rwa_divider import rwa_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  rwa_qstat_t                                    qstat,
  input  logic [SAMPLE_BITS+2*$clog2(MAX_WINDOW+1)-1:0] pop_data,
  output logic                                          pop,
  output logic                                          mean_valid,
  input  logic                                          mean_stall,
  output logic signed [SAMPLE_BITS-1:0]                 window_mean
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = SAMPLE_BITS + CW;
  localparam int NW = $clog2(SW + 1);

  div_state_t           state;
  logic [SW-1:0]        quo;
  logic [CW-1:0]        rem;
  logic [CW-1:0]        divisor;
  logic                 negative;
  logic [NW-1:0]        cnt;

  logic signed [SW-1:0] sum_in;
  logic [CW-1:0]        count_in;
  logic [CW:0]          rem_sh;
  logic                 fits;
  logic                 out_free;
  logic [SW-1:0]        quo_signed;

  assign sum_in   = signed'(pop_data[SW+CW-1:CW]);
  assign count_in = pop_data[CW-1:0];
  assign pop      = (state == DIV_IDLE) && !qstat.empty;
  assign out_free = !mean_valid || !mean_stall;

  // One restoring step per cycle
  assign rem_sh     = {rem, quo[SW-1]};
  assign fits       = (rem_sh >= {1'b0, divisor});
  assign quo_signed = negative ? (~quo + SW'(1)) : quo;

  // Division datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      quo      <= sum_in[SW-1] ? SW'(-sum_in) : SW'(sum_in);
      negative <= sum_in[SW-1];
      divisor  <= count_in;
      rem      <= '0;
      cnt      <= '0;
    end else if (state == DIV_RUN) begin
      rem <= fits ? CW'(rem_sh - {1'b0, divisor}) : rem_sh[CW-1:0];
      quo <= {quo[SW-2:0], fits};
      cnt <= cnt + NW'(1);
    end
  end

  // Load the result into the output register
  always_ff @(posedge clk) begin
    if (state == DIV_DONE && out_free) begin
      window_mean <= signed'(quo_signed[SAMPLE_BITS-1:0]);
    end
  end

  // Sequence divisions and the output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= DIV_IDLE;
      mean_valid <= 1'b0;
    end else begin
      if (state == DIV_DONE && out_free) begin
        mean_valid <= 1'b1;
      end else if (mean_valid && !mean_stall) begin
        mean_valid <= 1'b0;
      end
      unique case (state)
        DIV_IDLE: begin
          if (pop) begin
            state <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (cnt == NW'(SW - 1)) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (out_free) begin
            state <= DIV_IDLE;
          end
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

  // The last step hands over to the result stage
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    state == DIV_RUN && cnt == NW'(SW - 1) |=> state == DIV_DONE)
    else $error("divider overran its step count");

  // A queued count is never zero
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == DIV_RUN |-> divisor != '0)
    else $error("division by zero count");

endmodule

/* verif/rwa_checker.sv */
// Scoreboard for the running window average core: watches the config, sample
// and mean channels, predicts each mean and compares it in order.
// No dependencies beyond the port widths of running_window_average_core.
module rwa_checker #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [8:0]                    window_length,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          sequence_start,
  input  logic                          mean_valid,
  input  logic                          mean_stall,
  input  logic signed [SAMPLE_BITS-1:0] window_mean,
  output int                            fail_count,
  output int                            pending_means,
  output int                            means_checked
);

  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int COUNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int TOTAL_BITS = SAMPLE_BITS + COUNT_BITS;

  // Predicted window state
  logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
  logic [SLOT_BITS-1:0]          next_slot;
  logic [COUNT_BITS-1:0]         held_count;
  logic signed [TOTAL_BITS-1:0]  window_total;
  logic [8:0]                    window_setting;

  // Means predicted but not yet seen on the output
  logic signed [SAMPLE_BITS-1:0] expected_means [$];

  function automatic void clear_window();
    next_slot    = '0;
    held_count   = '0;
    window_total = '0;
  endfunction

  // Take one sample into the predicted window and return the new mean
  function automatic logic signed [SAMPLE_BITS-1:0] next_window_mean(
      input logic signed [SAMPLE_BITS-1:0] sample,
      input logic                          restart);
    int                   span;
    logic [SLOT_BITS-1:0] oldest;
    if (window_setting <= 1) begin
      span = 1;
    end else if (window_setting > MAX_WINDOW) begin
      span = MAX_WINDOW;
    end else begin
      span = window_setting;
    end
    if (restart) begin
      clear_window();
    end
    // Full window: drop the oldest sample before the new one lands on the ring
    if (held_count >= span) begin
      oldest = next_slot - SLOT_BITS'(span);
      window_total -= history[oldest];
      held_count = COUNT_BITS'(span);
    end else begin
      held_count++;
    end
    history[next_slot] = sample;
    window_total += sample;
    next_slot++;
    return SAMPLE_BITS'(longint'(window_total) / longint'(held_count));
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst) begin
      window_setting = 9'd1;
      clear_window();
      expected_means.delete();
      fail_count    = 0;
      means_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_setting = window_length;
        clear_window();
      end
      // Compare before queuing so a mean can never match its own sample
      if (mean_valid && !mean_stall) begin
        if (expected_means.size() == 0) begin
          $error("window_mean: no mean expected, got %0d", window_mean);
          fail_count++;
        end else begin
          want = expected_means[0];
          expected_means.delete(0);
          means_checked++;
          if (window_mean !== want) begin
            $error("window_mean: expected %0d, got %0d", want, window_mean);
            fail_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        expected_means.insert(expected_means.size(),
                              next_window_mean(sample_value, sequence_start));
      end
    end
    pending_means = expected_means.size();
  end

endmodule

/* verif/tb.sv */
// Testbench top for running_window_average_core: drives samples and window
// settings, stalls the mean channel, and reports the verdict.
// Depends on rwa_checker for prediction and comparison.
module tb;

  localparam int SAMPLE_BITS  = 32;
  localparam int MAX_WINDOW   = 256;
  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic signed [SAMPLE_BITS-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [8:0]                    window_length;
  logic                          sample_valid;
  logic                          sample_stall;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          sequence_start;
  logic                          mean_valid;
  logic                          mean_stall;
  logic signed [SAMPLE_BITS-1:0] window_mean;

  int fail_count;
  int pending_means;
  int means_checked;
  int burst_left    = 0;
  int samples_sent  = 0;
  int settings_used = 0;
  int idle_cycles   = 0;

  running_window_average_core #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (.*);

  rwa_checker #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the mean channel: none, coin flip, heavy or periodic, picked anew at random
  initial begin
    stall_mode_t mode;
    int          tick;
    mean_stall = 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        tick++;
        case (mode)
          STALL_NONE:  mean_stall = 1'b0;
          STALL_COIN:  mean_stall = 1'($urandom_range(0, 1));
          STALL_HEAVY: mean_stall = ($urandom_range(0, 7) != 0);
          default:     mean_stall = (tick % 5) < 2;
        endcase
      end
    end
  end

  // End the run if no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (mean_valid && !mean_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE;
      1:       return int'($urandom_range(0, 400)) - 200;
      2:       return MAX_SAMPLE - $urandom_range(0, 65535);
      3:       return MIN_SAMPLE + $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_sender();
    @(negedge clk);
    sample_valid = 1'b0;
  endtask

  // Send one sample transaction; bursts of random length with random gaps
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value,
                             input logic restart);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        sample_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    sample_valid   = 1'b1;
    sample_value   = value;
    sequence_start = restart;
    burst_left--;
    samples_sent++;
    do @(posedge clk); while (sample_stall);
  endtask

  // Write the window register once every outstanding mean has come back
  task automatic write_window(input logic [8:0] setting);
    idle_sender();
    while (pending_means != 0) @(negedge clk);
    cfg_valid     = 1'b1;
    window_length = setting;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  // One window setting, long enough to fill and wrap; noisy phases restart often
  task automatic run_phase(input logic [8:0] setting, input bit noisy);
    int span;
    int odds;
    int count;
    span  = (setting <= 1) ? 1 : (setting > MAX_WINDOW) ? MAX_WINDOW : int'(setting);
    odds  = noisy ? 3 : 4 * span + 8;
    count = span + $urandom_range(20, 60);
    write_window(setting);
    repeat (count) send_sample(pick_sample(), $urandom_range(1, odds) == 1);
  endtask

  initial begin
    int         directed_total;
    logic [8:0] setting;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    window_length  = 9'd1;
    sample_valid   = 1'b0;
    sample_value   = '0;
    sequence_start = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Window of one after reset: extremes pass straight through
    send_sample(0, 1'b0);
    send_sample(MAX_SAMPLE, 1'b0);
    send_sample(MIN_SAMPLE, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);

    // Window of four: hold the largest sum both ways and wrap through them
    write_window(9'd4);
    repeat (5) send_sample(MAX_SAMPLE, 1'b0);
    repeat (5) send_sample(MIN_SAMPLE, 1'b0);

    // Restart mid-stream; small negative sums truncate toward zero
    send_sample(-1, 1'b1);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-2, 1'b0);
    send_sample(-7, 1'b0);

    // Window of zero behaves as one
    write_window(9'd0);
    send_sample(32'sh1234_5678, 1'b0);
    send_sample(-5, 1'b1);
    directed_total = samples_sent;

    // Fixed settings: pass-through, tiny, largest, saturated above the ring size, 255 and 9
    run_phase(9'd0, 1'b0);
    run_phase(9'd1, 1'b1);
    run_phase(9'd2, 1'b0);
    run_phase(9'd3, 1'b1);
    run_phase(9'd256, 1'b0);
    run_phase(9'd511, 1'b0);
    run_phase(9'd257, 1'b0);
    run_phase(9'd255, 1'b0);
    run_phase(9'd9, 1'b0);

    // Random settings, mostly small windows
    while (samples_sent - directed_total < RANDOM_ITEMS) begin
      setting = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                             : 9'($urandom_range(2, 40));
      run_phase(setting, $urandom_range(0, 4) == 0);
    end

    // Drain the remaining means, then let the block settle
    idle_sender();
    while (pending_means != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d samples under %0d window settings (0, 1, small, 255 to 511).",
             samples_sent, settings_used);
    $display("Compared %0d means against the prediction; %0d mismatches.",
             means_checked, fail_count);
    if (fail_count == 0 && pending_means == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
